// ----- rtl/core/awpm_pkg.sv -----
// ----------------------------------------------------------------------------
// awpm_pkg
// Shared types, constants and the divider step for the alpha weighted
// pixel merge block.
// ----------------------------------------------------------------------------
package awpm_pkg;

   // Channel and alpha widths.
   localparam int CHAN_W   = 8;
   localparam int NCHAN    = 3;

   // Weighted sum of two 8-bit products and sum of two 8-bit weights.
   localparam int NUM_W    = 17;
   localparam int DEN_W    = 9;

   // The quotient never exceeds 255, so eight quotient bits suffice.
   localparam int QUO_W     = 8;
   localparam int QUO_IDX_W = 3;

   // Divider pipeline: two quotient bits resolved in each stage.
   localparam int DIV_BITS    = 2;
   localparam int DIV_STAGES  = QUO_W / DIV_BITS;
   localparam int DIV_STAGE_W = 2;

   // One input stage for weights and products, then the divider stages.
   localparam int PIPE_DEPTH  = DIV_STAGES + 1;

   localparam logic [CHAN_W-1:0] ALPHA_MAX    = 8'd255;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd0;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [NUM_W-1:0]  num_type;
   typedef logic [DEN_W-1:0]  den_type;
   typedef logic [QUO_W-1:0]  quo_type;

   // Partial remainder and quotient carried between divider stages.
   typedef struct packed {
      num_type rem;
      quo_type quo;
   } div_step_type;

   // Resolves DIV_BITS quotient bits of a restoring division for one stage.
   function automatic div_step_type div_step(input num_type rem,
                                             input den_type den,
                                             input quo_type quo,
                                             input logic [DIV_STAGE_W-1:0] stage);
      div_step_type res;
      num_type trial;
      logic [QUO_IDX_W-1:0] pos;
      res.rem = rem;
      res.quo = quo;
      for (int j = 0; j < DIV_BITS; j++) begin
         pos   = QUO_IDX_W'(QUO_W - 1 - int'(stage) * DIV_BITS - j);
         trial = NUM_W'(den) << pos;
         if (res.rem >= trial) begin
            res.rem      = res.rem - trial;
            res.quo[pos] = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/alpha_weighted_pixel_merge_top.sv -----
// ----------------------------------------------------------------------------
// alpha_weighted_pixel_merge_top
// Merges a source pixel into a destination pixel by alpha weighting.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_) carries one source and one destination pixel.
//   Alpha is a transparency: 0 is opaque and 255 is fully transparent.
//   The response channel (rsp_) returns one merged pixel for each request,
//   in order. Both channels use a valid/ready handshake.
//   A request passes through the input stage and four divider stages to
//   rsp_valid. One request is accepted every cycle while the receiver does
//   not stall: the first stage forms the weights and weighted sums, and four
//   divider stages resolve two quotient bits each for the three color channels.
//   When the receiver stalls, valid bits in the stages let empty slots
//   fill up; req_ready falls only when every stage holds a request and the
//   response is not taken. Nothing is dropped or repeated.
//   A synchronous, active-high reset empties the pipeline; no request is
//   accepted while reset is high.
// ----------------------------------------------------------------------------
module alpha_weighted_pixel_merge_top
   import awpm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CHAN_W-1:0]   req_src_alpha,
   input  logic [CHAN_W-1:0]   req_src_red,
   input  logic [CHAN_W-1:0]   req_src_green,
   input  logic [CHAN_W-1:0]   req_src_blue,
   input  logic [CHAN_W-1:0]   req_dst_alpha,
   input  logic [CHAN_W-1:0]   req_dst_red,
   input  logic [CHAN_W-1:0]   req_dst_green,
   input  logic [CHAN_W-1:0]   req_dst_blue,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CHAN_W-1:0]   rsp_out_alpha,
   output logic [CHAN_W-1:0]   rsp_out_red,
   output logic [CHAN_W-1:0]   rsp_out_green,
   output logic [CHAN_W-1:0]   rsp_out_blue
);

   // Pipeline registers and their next values.
   logic                 valid_ff  [PIPE_DEPTH];
   logic                 valid_in  [PIPE_DEPTH];
   logic                 stage_en  [PIPE_DEPTH];
   chan_type             alpha_ff  [PIPE_DEPTH];
   chan_type             alpha_in  [PIPE_DEPTH];
   den_type              den_ff    [PIPE_DEPTH];
   den_type              den_in    [PIPE_DEPTH];
   num_type              rem_ff    [PIPE_DEPTH][NCHAN];
   num_type              rem_in    [PIPE_DEPTH][NCHAN];
   quo_type              quo_ff    [PIPE_DEPTH][NCHAN];
   quo_type              quo_in    [PIPE_DEPTH][NCHAN];

   // Input stage working values.
   chan_type             src_chan  [NCHAN];
   chan_type             dst_chan  [NCHAN];
   chan_type             src_weight;
   chan_type             dst_weight;
   div_step_type         step_res;

   assign src_chan[0] = req_src_red;
   assign src_chan[1] = req_src_green;
   assign src_chan[2] = req_src_blue;
   assign dst_chan[0] = req_dst_red;
   assign dst_chan[1] = req_dst_green;
   assign dst_chan[2] = req_dst_blue;

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      stage_en[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
      for (int s = PIPE_DEPTH - 2; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
   end

   assign req_ready = stage_en[0] && !reset;

   // First stage: pick the case and form the dividend and divisor. The
   // pass-through cases divide the chosen channel by one, so every request
   // takes the same path through the divider. The divider stages after it
   // each resolve two quotient bits for every channel.
   always_comb begin
      src_weight = ALPHA_MAX - req_src_alpha;
      dst_weight = ALPHA_MAX - req_dst_alpha;
      valid_in[0] = req_valid;
      if (req_src_alpha == ALPHA_MAX) begin
         alpha_in[0] = req_dst_alpha;
         den_in[0]   = DEN_W'(1);
         for (int c = 0; c < NCHAN; c++) begin
            rem_in[0][c] = NUM_W'(dst_chan[c]);
         end
      end else if (req_src_alpha == ALPHA_OPAQUE) begin
         alpha_in[0] = ALPHA_OPAQUE;
         den_in[0]   = DEN_W'(1);
         for (int c = 0; c < NCHAN; c++) begin
            rem_in[0][c] = NUM_W'(src_chan[c]);
         end
      end else begin
         alpha_in[0] = (req_dst_alpha < req_src_alpha) ? req_dst_alpha : req_src_alpha;
         den_in[0]   = DEN_W'(src_weight) + DEN_W'(dst_weight);
         for (int c = 0; c < NCHAN; c++) begin
            rem_in[0][c] = NUM_W'(src_weight) * NUM_W'(src_chan[c])
                         + NUM_W'(dst_weight) * NUM_W'(dst_chan[c]);
         end
      end
      for (int c = 0; c < NCHAN; c++) begin
         quo_in[0][c] = '0;
      end

      step_res = '0;
      for (int s = 1; s < PIPE_DEPTH; s++) begin
         valid_in[s] = valid_ff[s-1];
         alpha_in[s] = alpha_ff[s-1];
         den_in[s]   = den_ff[s-1];
         for (int c = 0; c < NCHAN; c++) begin
            step_res = div_step(rem_ff[s-1][c], den_ff[s-1], quo_ff[s-1][c],
                                DIV_STAGE_W'(s - 1));
            rem_in[s][c] = step_res.rem;
            quo_in[s][c] = step_res.quo;
         end
      end
   end

   // Valid bits: cleared by reset, advanced with each stage enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_DEPTH; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s < PIPE_DEPTH; s++) begin
            if (stage_en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // Payload registers load under the same enables and need no reset.
   always_ff @(posedge clock) begin
      for (int s = 0; s < PIPE_DEPTH; s++) begin
         if (stage_en[s]) begin
            alpha_ff[s] <= alpha_in[s];
            den_ff[s]   <= den_in[s];
            for (int c = 0; c < NCHAN; c++) begin
               rem_ff[s][c] <= rem_in[s][c];
               quo_ff[s][c] <= quo_in[s][c];
            end
         end
      end
   end

   // The last stage is the response register.
   assign rsp_valid     = valid_ff[PIPE_DEPTH-1];
   assign rsp_out_alpha = alpha_ff[PIPE_DEPTH-1];
   assign rsp_out_red   = quo_ff[PIPE_DEPTH-1][0];
   assign rsp_out_green = quo_ff[PIPE_DEPTH-1][1];
   assign rsp_out_blue  = quo_ff[PIPE_DEPTH-1][2];

endmodule

// ----- rtl/core/awpm_checker.sv -----
// ----------------------------------------------------------------------------
// awpm_checker
// Port-level checks for the alpha weighted pixel merge block.
// ----------------------------------------------------------------------------
module awpm_checker
   import awpm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_ready,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [CHAN_W-1:0]   rsp_out_alpha,
   input  logic [CHAN_W-1:0]   rsp_out_red,
   input  logic [CHAN_W-1:0]   rsp_out_green,
   input  logic [CHAN_W-1:0]   rsp_out_blue
);

   // Reset empties the pipeline, so no response is shown right after it.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Request backpressure only comes from a stalled response.
   assert property (@(posedge clock) disable iff (reset)
                    !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a stalled response");

   // A stalled response stays valid.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_ready) |=>
                    ($stable(rsp_out_alpha) && $stable(rsp_out_red) &&
                     $stable(rsp_out_green) && $stable(rsp_out_blue)))
      else $error("response payload changed while stalled");

endmodule

bind alpha_weighted_pixel_merge_top awpm_checker u_awpm_checker (.*);

// ----- dv/tb_alpha_weighted_pixel_merge_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alpha_weighted_pixel_merge_top
// Self-checking bench for the alpha weighted pixel merge block. A small
// scoreboard predicts every merged pixel from the accepted requests and
// checks responses in order. Stimulus is a directed set of corner pixels
// followed by random pixel pairs under changing idle patterns on both
// sides, including a long receiver hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_alpha_weighted_pixel_merge_top;
   import awpm_pkg::*;

   // One pixel as it travels on the ports.
   typedef struct packed {
      chan_type alpha;
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   // One request: the source pixel merged into the destination pixel.
   typedef struct packed {
      pixel_type src;
      pixel_type dst;
   } merge_request_type;

   localparam int RANDOM_PER_PHASE = 500;
   localparam int HOLD_OFF_CYCLES  = 64;
   localparam int DRAIN_CYCLES     = 12;
   localparam int MAX_REPORTS      = 10;

   // Predicts merged pixels and checks the responses against them.
   class pixel_merge_scoreboard;
      pixel_type expected_pixels[$];
      int     requests;
      int     responses;
      int     errors;
      int     transparent_count;
      int     opaque_count;
      int     blend_count;

      // Floor of the weighted mean of one color channel.
      function chan_type weighted_mean(chan_type w_src, chan_type c_src,
                                       chan_type w_dst, chan_type c_dst);
         num_type sum;
         den_type weights;
         sum     = num_type'(w_src) * num_type'(c_src) + num_type'(w_dst) * num_type'(c_dst);
         weights = den_type'(w_src) + den_type'(w_dst);
         return chan_type'(sum / num_type'(weights));
      endfunction

      // Computes the merged pixel for one request.
      function pixel_type merge_pixel(merge_request_type rq);
         pixel_type merged;
         chan_type  w_src;
         chan_type  w_dst;
         if (rq.src.alpha == ALPHA_MAX) begin
            transparent_count++;
            return rq.dst;
         end
         if (rq.src.alpha == ALPHA_OPAQUE) begin
            opaque_count++;
            return rq.src;
         end
         blend_count++;
         w_src        = ALPHA_MAX - rq.src.alpha;
         w_dst        = ALPHA_MAX - rq.dst.alpha;
         merged.alpha = (rq.dst.alpha < rq.src.alpha) ? rq.dst.alpha : rq.src.alpha;
         merged.red   = weighted_mean(w_src, rq.src.red, w_dst, rq.dst.red);
         merged.green = weighted_mean(w_src, rq.src.green, w_dst, rq.dst.green);
         merged.blue  = weighted_mean(w_src, rq.src.blue, w_dst, rq.dst.blue);
         return merged;
      endfunction

      function void note_request(merge_request_type rq);
         requests++;
         expected_pixels.push_back(merge_pixel(rq));
      endfunction

      function void check_response(pixel_type actual);
         pixel_type want;
         responses++;
         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR: response %h arrived with no request outstanding", actual);
            return;
         end
         want = expected_pixels.pop_front();
         if (actual.alpha !== want.alpha || actual.red !== want.red ||
             actual.green !== want.green || actual.blue !== want.blue) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR: response %0d: expected a=%h r=%h g=%h b=%h, got a=%h r=%h g=%h b=%h",
                        responses, want.alpha, want.red, want.green, want.blue,
                        actual.alpha, actual.red, actual.green, actual.blue);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   chan_type req_src_alpha, req_src_red, req_src_green, req_src_blue;
   chan_type req_dst_alpha, req_dst_red, req_dst_green, req_dst_blue;
   logic     rsp_valid;
   logic     rsp_ready;
   chan_type rsp_out_alpha, rsp_out_red, rsp_out_green, rsp_out_blue;

   pixel_merge_scoreboard merge_sb = new();

   int send_idle_pct;
   int rsp_idle_pct;
   bit hold_off_pending;
   int input_stall_cycles;

   alpha_weighted_pixel_merge_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_src_alpha (req_src_alpha),
      .req_src_red   (req_src_red),
      .req_src_green (req_src_green),
      .req_src_blue  (req_src_blue),
      .req_dst_alpha (req_dst_alpha),
      .req_dst_red   (req_dst_red),
      .req_dst_green (req_dst_green),
      .req_dst_blue  (req_dst_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

   // Clock with a 2 ns period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Response monitor and input back-pressure count.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            merge_sb.check_response({rsp_out_alpha, rsp_out_red, rsp_out_green, rsp_out_blue});
         if (req_valid && !req_ready)
            input_stall_cycles++;
      end
   end

   // Receiver: random ready, or a long hold-off when one is asked for.
   initial begin
      int hold_count;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready        = 1'b0;
            for (hold_count = 1; hold_count < HOLD_OFF_CYCLES; hold_count++)
               @(negedge clock);
         end else begin
            rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offers one request, with random gaps before it, and waits until it is taken.
   // Called and returns at a falling edge.
   task automatic send_request(input merge_request_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_src_alpha = rq.src.alpha;
      req_src_red   = rq.src.red;
      req_src_green = rq.src.green;
      req_src_blue  = rq.src.blue;
      req_dst_alpha = rq.dst.alpha;
      req_dst_red   = rq.dst.red;
      req_dst_green = rq.dst.green;
      req_dst_blue  = rq.dst.blue;
      do
         @(posedge clock);
      while (!req_ready);
      merge_sb.note_request(rq);
      @(negedge clock);
   endtask

   // Color value with extra weight on the ends of the range.
   function automatic chan_type random_chan();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8)
         return 8'h00;
      if (pick < 16)
         return 8'hFF;
      return chan_type'($urandom_range(255));
   endfunction

   // Alpha with the pass-through values and their neighbors well represented.
   function automatic chan_type random_alpha();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15)
         return ALPHA_OPAQUE;
      if (pick < 30)
         return ALPHA_MAX;
      if (pick < 35)
         return 8'd1;
      if (pick < 40)
         return 8'd254;
      return chan_type'($urandom_range(255));
   endfunction

   function automatic merge_request_type random_request();
      merge_request_type rq;
      rq.src = '{random_alpha(), random_chan(), random_chan(), random_chan()};
      rq.dst = '{random_alpha(), random_chan(), random_chan(), random_chan()};
      return rq;
   endfunction

   task automatic send_random_phase(input int sender_pct, input int receiver_pct,
                                    input bit with_hold_off);
      int n;
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
         if (with_hold_off && n == RANDOM_PER_PHASE / 4)
            hold_off_pending = 1'b1;
         send_request(random_request());
      end
   endtask

   // Corner pixels: both pass-through alphas, blend extremes, alpha ordering.
   merge_request_type corner_requests[] = '{
      '{'{8'hFF, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h12, 8'h34, 8'h56}},
      '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      '{'{8'hFF, 8'hAA, 8'h55, 8'h0F}, '{8'h80, 8'hF0, 8'h0F, 8'h81}},
      '{'{8'h00, 8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'h00, 8'h00}},
      '{'{8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'hFF, 8'hFF}},
      '{'{8'h00, 8'h5A, 8'hA5, 8'h3C}, '{8'h7F, 8'h11, 8'h22, 8'h33}},
      '{'{8'h01, 8'hFF, 8'h80, 8'h00}, '{8'hFF, 8'h00, 8'h7F, 8'hFF}},
      '{'{8'hFE, 8'h00, 8'hFF, 8'h40}, '{8'hFF, 8'hFF, 8'h00, 8'hC0}},
      '{'{8'h01, 8'hFF, 8'hFF, 8'hFF}, '{8'h00, 8'hFF, 8'hFF, 8'hFF}},
      '{'{8'h01, 8'hFF, 8'h00, 8'hFF}, '{8'h01, 8'h00, 8'hFF, 8'h00}},
      '{'{8'hFE, 8'hFF, 8'h00, 8'hFF}, '{8'hFE, 8'h00, 8'hFF, 8'h01}},
      '{'{8'hFE, 8'hFF, 8'hFF, 8'hFF}, '{8'h00, 8'h00, 8'h00, 8'h00}},
      '{'{8'h01, 8'h00, 8'h00, 8'h00}, '{8'hFE, 8'hFF, 8'hFF, 8'hFF}},
      '{'{8'h80, 8'h64, 8'hC8, 8'h01}, '{8'h40, 8'h32, 8'h10, 8'hFE}},
      '{'{8'h40, 8'h64, 8'hC8, 8'h01}, '{8'h80, 8'h32, 8'h10, 8'hFE}},
      '{'{8'h77, 8'h0D, 8'hE3, 8'h99}, '{8'h77, 8'hB2, 8'h1C, 8'h66}},
      '{'{8'hC3, 8'h7F, 8'h80, 8'h7F}, '{8'h3C, 8'h80, 8'h7F, 8'h80}}
   };

   // Main sequence: reset, directed pixels, three random phases, drain.
   initial begin
      int drain;
      reset            = 1'b1;
      req_valid        = 1'b0;
      {req_src_alpha, req_src_red, req_src_green, req_src_blue} = '0;
      {req_dst_alpha, req_dst_red, req_dst_green, req_dst_blue} = '0;
      send_idle_pct    = 0;
      rsp_idle_pct     = 0;
      hold_off_pending = 1'b0;
      input_stall_cycles = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (corner_requests[k])
         send_request(corner_requests[k]);

      send_random_phase(36, 72, 1'b0);
      send_random_phase(72, 36, 1'b0);
      send_random_phase(0, 0, 1'b1);
      req_valid = 1'b0;

      // Wait for the last responses, then watch for strays.
      while (merge_sb.pending() != 0)
         @(posedge clock);
      for (drain = 0; drain < DRAIN_CYCLES; drain++)
         @(posedge clock);

      $display("Merged %0d pixel pairs: %0d transparent source, %0d opaque source, %0d blended.",
               merge_sb.requests, merge_sb.transparent_count, merge_sb.opaque_count,
               merge_sb.blend_count);
      $display("Input was held off for %0d cycles; %0d mismatches found.",
               input_stall_cycles, merge_sb.errors);
      if (merge_sb.errors == 0 && merge_sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #400000;
      $display("ERROR: run did not finish in time, %0d responses outstanding",
               merge_sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/awpm_pkg.sv
rtl/core/alpha_weighted_pixel_merge_top.sv
rtl/core/awpm_checker.sv
dv/tb_alpha_weighted_pixel_merge_top.sv
